[sv/tcce_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the text console cursor engine.
package tcce_pkg;

    // Command codes of an input transaction
    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [7:0] CH_NEWLINE  = 8'd10;
    localparam logic [7:0] CH_RETURN   = 8'd13;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] RESET_COLOR = 8'd15;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // latch the input transaction
        logic exec;       // decode the item, move the cursor, issue a read
        logic fill;       // write one blank cell at the sweep counter
        logic fill_init;  // blank in reset color instead of text color
        logic scroll;     // one step of the scroll copy
        logic capture;    // take read data into the result
        logic deliver;    // load the output register
        logic cnt_clear;  // restart the sweep counter
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic need_scroll;
        logic read_ok;
        logic fill_done;
        logic scroll_done;
        logic out_free;
    } dp_status_t;

endpackage

[sv/text_console_cursor_engine_core.sv]
`timescale 1ns / 1ps
// Top level of the text console cursor engine.
//
// Character-cell console: a ROWS x COLS store of 16-bit cells (attribute in
// the high byte, character in the low byte) and a cursor.
// Input channel (in_valid/in_stall): one transaction carries cmd, char_code,
// read_row and read_col. Put character, clear screen or read one cell.
// Output channel (out_valid/out_stall): exactly one result per input
// transaction, in order: cell_word, cursor position after the item, and
// did_scroll.
// Items are handled one at a time. A plain put, carriage return, newline
// without scroll or unused command goes from acceptance through S_EXEC and
// S_DONE, where the result is loaded into the output register. A read of a
// cell in range also passes S_READ for the registered store read.
// A scroll walks the store in S_SCROLL (copy one cell a cycle, then blank the
// bottom row). A clear blanks all ROWS*COLS cells in S_CLEAR.
// Reset: the cursor goes home, text_color returns to 15, and a blanking pass
// writes 0x0F20 to every cell; in_stall stays high until it ends.
// text_color_we/text_color are accepted at any time.
// Output stall: the result waits in the output register; the next item is
// still accepted and worked on, and waits for the register to empty.
module text_console_cursor_engine_core import tcce_pkg::*; #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_color_we,
    input  logic [7:0]  text_color,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  char_code,
    input  logic [4:0]  read_row,
    input  logic [6:0]  read_col,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] cell_word,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_col,
    output logic        did_scroll
);

    ctrl_cmd_t  ctrl;
    dp_status_t status;

    // Sequencer: owns the input handshake and drives datapath commands
    tcce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .ctrl     (ctrl)
    );

    // Datapath: cursor, store, sweep counter and the output register
    tcce_dp #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .status        (status),
        .text_color_we (text_color_we),
        .text_color    (text_color),
        .cmd           (cmd),
        .char_code     (char_code),
        .read_row      (read_row),
        .read_col      (read_col),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cell_word     (cell_word),
        .cursor_row    (cursor_row),
        .cursor_col    (cursor_col),
        .did_scroll    (did_scroll)
    );

endmodule

[sv/tcce_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/tcce_ctrl.sv]
`timescale 1ns / 1ps
// Sequencing state machine of the text console cursor engine.
module tcce_ctrl import tcce_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  ctrl
);

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_EXEC   = 8'b0000_0100,
        S_READ   = 8'b0000_1000,
        S_SCROLL = 8'b0001_0000,
        S_CLEAR  = 8'b0010_0000,
        S_DONE   = 8'b0100_0000,
        S_SPARE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            S_INIT:
            begin
                ctrl.fill      = 1'b1;
                ctrl.fill_init = 1'b1;
                if (status.fill_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.accept = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctrl.exec      = 1'b1;
                ctrl.cnt_clear = 1'b1;
                unique case (status.cmd)
                    CMD_PUT:   state_next = status.need_scroll ? S_SCROLL : S_DONE;
                    CMD_CLEAR: state_next = S_CLEAR;
                    CMD_READ:  state_next = status.read_ok ? S_READ : S_DONE;
                    default:   state_next = S_DONE;
                endcase
            end
            S_READ:
            begin
                ctrl.capture = 1'b1;
                state_next   = S_DONE;
            end
            S_SCROLL:
            begin
                ctrl.scroll = 1'b1;
                if (status.scroll_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_CLEAR:
            begin
                ctrl.fill = 1'b1;
                if (status.fill_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    ctrl.deliver = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/tcce_dp.sv]
`timescale 1ns / 1ps
// Datapath: cursor, color register, screen store, sweep counter and output register.
module tcce_dp import tcce_pkg::*; #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   ctrl,
    output dp_status_t  status,
    input  logic        text_color_we,
    input  logic [7:0]  text_color,
    input  logic [1:0]  cmd,
    input  logic [7:0]  char_code,
    input  logic [4:0]  read_row,
    input  logic [6:0]  read_col,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] cell_word,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_col,
    output logic        did_scroll
);

    localparam int N     = ROWS * COLS;
    localparam int M     = (ROWS - 1) * COLS;
    localparam int AW    = $clog2(N);
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);
    localparam int CNT_W = $clog2(N + 1);

    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [7:0]       color_reg;
    cmd_t             cmd_reg;
    logic [7:0]       char_reg;
    logic [4:0]       rrow_reg;
    logic [6:0]       rcol_reg;
    logic [15:0]      cell_reg;
    logic             scroll_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;
    logic [15:0]      cell_word_reg;
    logic [4:0]       cursor_row_reg;
    logic [6:0]       cursor_col_reg;
    logic             did_scroll_reg;

    logic             is_nl;
    logic             is_cr;
    logic             last_col;
    logic             last_row;
    logic             adv_row;
    logic             printable;
    logic             need_scroll;
    logic             read_ok;
    logic [AW-1:0]    cur_addr;
    logic [AW-1:0]    rd_addr;
    logic [CNT_W-1:0] cnt_dec;
    logic [CNT_W-1:0] cnt_src;
    logic [7:0]       fill_color;
    logic [31:0]      row_ext;
    logic [31:0]      col_ext;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [15:0]      wdata;
    logic [AW-1:0]    raddr;
    logic [15:0]      rdata;

    // Item decode against the current cursor
    assign is_nl       = (char_reg == CH_NEWLINE);
    assign is_cr       = (char_reg == CH_RETURN);
    assign last_col    = (col_reg == COL_W'(COLS - 1));
    assign last_row    = (row_reg == ROW_W'(ROWS - 1));
    assign printable   = !is_nl && !is_cr;
    assign adv_row     = is_nl || (printable && last_col);
    assign need_scroll = (cmd_reg == CMD_PUT) && adv_row && last_row;
    assign read_ok     = (int'(rrow_reg) < ROWS) && (int'(rcol_reg) < COLS);

    assign cur_addr = AW'(row_reg) * AW'(COLS) + AW'(col_reg);
    assign rd_addr  = AW'(rrow_reg) * AW'(COLS) + AW'(rcol_reg);
    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign cnt_src  = cnt_reg + CNT_W'(COLS);

    assign fill_color = ctrl.fill_init ? RESET_COLOR : color_reg;

    // Store write and read port selection
    always_comb
    begin
        we    = 1'b0;
        waddr = AW'(cnt_reg);
        wdata = {fill_color, CH_SPACE};
        if (ctrl.fill)
        begin
            we = 1'b1;
        end
        else if (ctrl.scroll)
        begin
            // the write follows the read of the row below in the next cycle
            we    = (cnt_reg != '0);
            waddr = AW'(cnt_dec);
            wdata = (cnt_reg <= CNT_W'(M)) ? rdata : {color_reg, CH_SPACE};
        end
        else if (ctrl.exec && cmd_reg == CMD_PUT && printable)
        begin
            we    = 1'b1;
            waddr = cur_addr;
            wdata = {color_reg, char_reg};
        end
    end

    assign raddr = ctrl.exec ? rd_addr : AW'(cnt_src);

    tcce_ram #(
        .WIDTH (16),
        .DEPTH (N)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Control registers: cursor, color, counter, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            color_reg     <= RESET_COLOR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (text_color_we)
            begin
                color_reg <= text_color;
            end
            if (ctrl.exec && cmd_reg == CMD_PUT)
            begin
                if (!printable || last_col)
                begin
                    col_reg <= '0;
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
                if (adv_row && !last_row)
                begin
                    row_reg <= row_reg + ROW_W'(1);
                end
            end
            if (ctrl.cnt_clear)
            begin
                cnt_reg <= '0;
            end
            else if (ctrl.fill || ctrl.scroll)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (ctrl.deliver)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign row_ext = 32'(row_reg);
    assign col_ext = 32'(col_reg);

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg  <= cmd_t'(cmd);
            char_reg <= char_code;
            rrow_reg <= read_row;
            rcol_reg <= read_col;
        end
        if (ctrl.exec)
        begin
            cell_reg   <= '0;
            scroll_reg <= need_scroll;
        end
        else if (ctrl.capture)
        begin
            cell_reg <= rdata;
        end
        if (ctrl.deliver)
        begin
            cell_word_reg  <= cell_reg;
            cursor_row_reg <= row_ext[4:0];
            cursor_col_reg <= col_ext[6:0];
            did_scroll_reg <= scroll_reg;
        end
    end

    assign status.cmd         = cmd_reg;
    assign status.need_scroll = need_scroll;
    assign status.read_ok     = read_ok;
    assign status.fill_done   = (cnt_reg == CNT_W'(N - 1));
    assign status.scroll_done = (cnt_reg == CNT_W'(N));
    assign status.out_free    = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign cell_word  = cell_word_reg;
    assign cursor_row = cursor_row_reg;
    assign cursor_col = cursor_col_reg;
    assign did_scroll = did_scroll_reg;

endmodule

[sv/tcce_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the text console cursor engine and their binding.
module tcce_checker #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input logic        clk,
    input logic        rst_n,
    input logic        text_color_we,
    input logic [7:0]  text_color,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  cmd,
    input logic [7:0]  char_code,
    input logic [4:0]  read_row,
    input logic [6:0]  read_col,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] cell_word,
    input logic [4:0]  cursor_row,
    input logic [6:0]  cursor_col,
    input logic        did_scroll
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cell_word)
            && $stable(cursor_row) && $stable(cursor_col) && $stable(did_scroll))
        else $error("stalled result changed");

    // One item at a time: stall right after an accepted transaction
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while one is in flight");

    // A scroll leaves the cursor on the bottom row and returns no cell
    a_scroll_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && did_scroll |-> cursor_row == 5'(ROWS - 1) && cell_word == 16'd0
            && int'(cursor_col) < COLS)
        else $error("bad scroll result");

endmodule

bind text_console_cursor_engine_core tcce_checker #(
    .COLS (COLS),
    .ROWS (ROWS)
) u_tcce_checker (.*);
